// ===== rtl/bhpr_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpr_pkg
// shared widths, register indexes, reset values and defect codes
// ----------------------------------------------------------------------------
`default_nettype none

package bhpr_pkg;

  // port field widths
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 14;
  localparam int SAMPLE_PORT_BITS = 14;
  localparam int PIX_OUT_BITS     = 15;
  localparam int KIND_BITS        = 2;
  localparam int TOTAL_BITS       = 27;
  localparam int DIM_BITS         = 14;
  localparam int GAIN_BITS        = 13;

  // parameter defaults
  localparam int MAX_WIDTH_DEFAULT   = 8192;
  localparam int SAMPLE_BITS_DEFAULT = 14;

  // line store rows kept in flight
  localparam int ROW_SLOTS = 8;
  localparam int SLOT_BITS = 3;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_EXCESS   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPREAD_Q8    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPAIR_DARK  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd4;

  // register reset values
  localparam logic [GAIN_BITS-1:0] MIN_EXCESS_RESET   = 13'd500;
  localparam logic [GAIN_BITS-1:0] SPREAD_Q8_RESET    = 13'd1536;
  localparam logic [DIM_BITS-1:0]  FRAME_WIDTH_RESET  = 14'd4096;
  localparam logic [DIM_BITS-1:0]  FRAME_HEIGHT_RESET = 14'd4096;

  // input commands
  localparam logic CMD_PIXEL = 1'b0;

  // defect codes
  localparam logic [KIND_BITS-1:0] KIND_KEPT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_HOT  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_COLD = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/bhpr_stream_if.sv =====
// ----------------------------------------------------------------------------
// bhpr_stream_if
// valid/ready channels for raw samples in and repaired sensels out
// ----------------------------------------------------------------------------
`default_nettype none

interface bhpr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic [bhpr_pkg::SAMPLE_PORT_BITS-1:0]  sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

interface bhpr_out_if;
  logic                               valid;
  logic                               ready;
  logic [bhpr_pkg::PIX_OUT_BITS-1:0]  pixel_half_levels;
  logic [bhpr_pkg::KIND_BITS-1:0]     defect_kind;
  logic                               frame_end;
  logic [bhpr_pkg::TOTAL_BITS-1:0]    repair_total;

  modport source (output valid, output pixel_half_levels, output defect_kind,
                  output frame_end, output repair_total, input ready);
  modport sink   (input valid, input pixel_half_levels, input defect_kind,
                  input frame_end, input repair_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/bayer_hot_pixel_repair.sv =====
// ----------------------------------------------------------------------------
// bayer_hot_pixel_repair
// path: a result is registered through the window, sort, decision and output
//   stages; releases trail the input by 2*width+2 pixels, drains flush
// throughput: 1 item per cycle with the skid slot empty; one write, two reads per bank
// reset: synchronous, registers to defaults, counters cleared, line store
//   left unwritten (every read hits rows already written in the frame)
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_hot_pixel_repair #(
  parameter int MAX_WIDTH   = bhpr_pkg::MAX_WIDTH_DEFAULT,
  parameter int SAMPLE_BITS = bhpr_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bhpr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [bhpr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  bhpr_in_if.sink                                  in_ch,
  bhpr_out_if.source                               out_ch
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 1;                    // half-level values
  localparam int XW = $clog2(MAX_WIDTH);         // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);     // width value
  localparam int DW = XW + 3;                    // received minus released
  localparam int HW = bhpr_pkg::DIM_BITS;
  localparam int GW = bhpr_pkg::GAIN_BITS;
  localparam int LW = GW + SB;                   // spread product
  localparam int MW = SB + 15;                   // signed compare width
  localparam int NS = bhpr_pkg::ROW_SLOTS;
  localparam int TW = bhpr_pkg::TOTAL_BITS;

  typedef logic [SB-1:0] smp_t;
  typedef smp_t nbr_arr_t [8];

  // compare-exchange for the sorting network
  function automatic nbr_arr_t cas(input nbr_arr_t v, input logic [2:0] i,
                                   input logic [2:0] j);
    nbr_arr_t r;
    r = v;
    if (v[i] > v[j]) begin
      r[i] = v[j];
      r[j] = v[i];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [GW-1:0] min_excess;
  logic [GW-1:0] spread_q8;
  logic          repair_dark;
  logic [HW-1:0] frame_width;
  logic [HW-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_excess   <= bhpr_pkg::MIN_EXCESS_RESET;
      spread_q8    <= bhpr_pkg::SPREAD_Q8_RESET;
      repair_dark  <= 1'b0;
      frame_width  <= bhpr_pkg::FRAME_WIDTH_RESET;
      frame_height <= bhpr_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bhpr_pkg::CFG_MIN_EXCESS:   min_excess   <= cfg_data[GW-1:0];
        bhpr_pkg::CFG_SPREAD_Q8:    spread_q8    <= cfg_data[GW-1:0];
        bhpr_pkg::CFG_REPAIR_DARK:  repair_dark  <= cfg_data[0];
        bhpr_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[HW-1:0];
        bhpr_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: the whole pipe moves unless the skid slot is occupied
  // --------------------------------------------------------------------------
  logic skid_valid;
  logic adv;
  logic hs;

  assign adv         = !skid_valid;
  assign in_ch.ready = adv;
  assign hs          = in_ch.valid && adv;

  // --------------------------------------------------------------------------
  // issue stage: raster counters, line store write, window read addresses
  // --------------------------------------------------------------------------
  logic [WW-1:0] lat_w;
  logic [HW-1:0] lat_h;
  logic [XW-1:0] col;
  logic [HW-1:0] row;
  logic [XW-1:0] px;
  logic [HW-1:0] py;
  logic [DW-1:0] diff;     // pixels stored but not yet released

  logic [WW-1:0] eff_w, cur_w, col_inc;
  logic [HW-1:0] eff_h, cur_h;
  logic          is_pix, idle, acc, emit, last_out, col_wrap;
  logic [DW-1:0] lag;
  logic [WW:0]   px2;
  logic [HW:0]   py2;
  logic [XW-1:0] rd_r;
  logic [HW-1:0] ry0, ry2;
  smp_t          s_in;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    eff_h  = (frame_height == '0) ? HW'(1) : frame_height;
    is_pix = (in_ch.command == bhpr_pkg::CMD_PIXEL);
    idle   = (col == '0) && (row == '0) && (px == '0) && (py == '0);
    // the frame size is taken up by the first pixel of a frame
    cur_w  = (is_pix && idle) ? eff_w : lat_w;
    cur_h  = (is_pix && idle) ? eff_h : lat_h;
    // a pixel past the frame's last one is dropped and acts as a drain
    acc    = is_pix && (row < cur_h);
    lag    = DW'({cur_w, 1'b0}) + DW'(2);
    // release once the bottom-right neighbor is in the store
    emit   = acc ? (diff >= lag) : (row >= cur_h);
    col_inc  = WW'(col) + WW'(1);
    col_wrap = (col_inc >= cur_w);
    last_out = ((WW'(px) + WW'(1)) == cur_w) &&
               ((HW'(py) + HW'(1)) == cur_h);
    // clamped columns and rows of the same-color ring
    px2  = (WW+1)'(px) + (WW+1)'(2);
    rd_r = (px2 >= (WW+1)'(cur_w)) ? XW'(cur_w - WW'(1)) : XW'(px2);
    ry0  = (py < HW'(2)) ? '0 : py - HW'(2);
    py2  = (HW+1)'(py) + (HW+1)'(2);
    ry2  = (py2 >= (HW+1)'(cur_h)) ? cur_h - HW'(1) : py2[HW-1:0];
    s_in = SB'(in_ch.sample);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_w <= WW'(bhpr_pkg::FRAME_WIDTH_RESET);
      lat_h <= bhpr_pkg::FRAME_HEIGHT_RESET;
      col   <= '0;
      row   <= '0;
      px    <= '0;
      py    <= '0;
      diff  <= '0;
    end else if (hs) begin
      if (is_pix && idle) begin
        lat_w <= eff_w;
        lat_h <= eff_h;
      end
      if (acc) begin
        if (col_wrap) begin
          col <= '0;
          row <= row + HW'(1);
        end else begin
          col <= XW'(col_inc);
        end
      end
      if (acc && !emit) begin
        diff <= diff + DW'(1);
      end else if (!acc && emit) begin
        diff <= diff - DW'(1);
      end
      if (emit) begin
        if (last_out) begin
          // frame done: everything back to the start
          px   <= '0;
          py   <= '0;
          col  <= '0;
          row  <= '0;
          diff <= '0;
        end else if ((WW'(px) + WW'(1)) == cur_w) begin
          px <= '0;
          py <= py + HW'(1);
        end else begin
          px <= px + XW'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // line store: one bank per row slot, each with one write and two reads
  // (center column and clamped right column)
  // --------------------------------------------------------------------------
  logic                          mem_we;
  logic [bhpr_pkg::SLOT_BITS-1:0] mem_wslot;
  smp_t                          bank_c [NS];
  smp_t                          bank_r [NS];

  assign mem_we    = hs && acc;
  assign mem_wslot = row[bhpr_pkg::SLOT_BITS-1:0];

  for (genvar b = 0; b < NS; b++) begin : g_bank
    smp_t bank_mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (mem_we && (mem_wslot == bhpr_pkg::SLOT_BITS'(b))) begin
        bank_mem[col] <= s_in;
      end
      if (adv) begin
        bank_c[b] <= bank_mem[px];
        bank_r[b] <= bank_mem[rd_r];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: bank select, write forwarding, left column from history
  // --------------------------------------------------------------------------
  logic                           v1, fend1, px0_1, px1_1;
  logic [bhpr_pkg::SLOT_BITS-1:0] slot1 [3];
  logic                           f_we, f_c, f_r;
  logic [bhpr_pkg::SLOT_BITS-1:0] f_slot;
  smp_t                           f_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= hs && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fend1    <= last_out;
      px0_1    <= (px == '0);
      px1_1    <= (px == XW'(1));
      slot1[0] <= ry0[bhpr_pkg::SLOT_BITS-1:0];
      slot1[1] <= py[bhpr_pkg::SLOT_BITS-1:0];
      slot1[2] <= ry2[bhpr_pkg::SLOT_BITS-1:0];
      // the newest sample may be read in the cycle it is written
      f_we     <= mem_we;
      f_slot   <= mem_wslot;
      f_data   <= s_in;
      f_c      <= (col == px);
      f_r      <= (col == rd_r);
    end
  end

  smp_t lv [3];
  smp_t cv [3];
  smp_t rv [3];
  smp_t hist1 [3];
  smp_t hist2 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cv[r] = (f_we && f_c && (f_slot == slot1[r])) ? f_data : bank_c[slot1[r]];
      rv[r] = (f_we && f_r && (f_slot == slot1[r])) ? f_data : bank_r[slot1[r]];
      // left column is the center column two pixels back, clamped at col 0
      if (px0_1) begin
        lv[r] = cv[r];
      end else if (px1_1) begin
        lv[r] = hist1[r];
      end else begin
        lv[r] = hist2[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      for (int r = 0; r < 3; r++) begin
        hist2[r] <= hist1[r];
        hist1[r] <= cv[r];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2 and 3: odd-even merge sort of the eight neighbors
  // --------------------------------------------------------------------------
  logic     v2, fend2, v3, fend3, v4, fend4;
  smp_t     cen2, cen3, cen4;
  nbr_arr_t nb2, nb3, nb4;
  nbr_arr_t sa, sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_comb begin
    sa = nb2;
    sa = cas(sa, 3'd0, 3'd1);
    sa = cas(sa, 3'd2, 3'd3);
    sa = cas(sa, 3'd4, 3'd5);
    sa = cas(sa, 3'd6, 3'd7);
    sa = cas(sa, 3'd0, 3'd2);
    sa = cas(sa, 3'd1, 3'd3);
    sa = cas(sa, 3'd4, 3'd6);
    sa = cas(sa, 3'd5, 3'd7);
    sa = cas(sa, 3'd1, 3'd2);
    sa = cas(sa, 3'd5, 3'd6);
    sb = nb3;
    sb = cas(sb, 3'd0, 3'd4);
    sb = cas(sb, 3'd1, 3'd5);
    sb = cas(sb, 3'd2, 3'd6);
    sb = cas(sb, 3'd3, 3'd7);
    sb = cas(sb, 3'd2, 3'd4);
    sb = cas(sb, 3'd3, 3'd5);
    sb = cas(sb, 3'd1, 3'd2);
    sb = cas(sb, 3'd3, 3'd4);
    sb = cas(sb, 3'd5, 3'd6);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fend2  <= fend1;
      cen2   <= cv[1];
      nb2[0] <= lv[0];
      nb2[1] <= cv[0];
      nb2[2] <= rv[0];
      nb2[3] <= lv[1];
      nb2[4] <= rv[1];
      nb2[5] <= lv[2];
      nb2[6] <= cv[2];
      nb2[7] <= rv[2];
      fend3  <= fend2;
      cen3   <= cen2;
      nb3    <= sa;
      fend4  <= fend3;
      cen4   <= cen3;
      nb4    <= sb;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: median, excess and spread product
  // --------------------------------------------------------------------------
  logic                 v5, fend5, gt5, lt5;
  logic [PW-1:0]        m2_5, c2_5;
  logic signed [PW:0]   up5;
  logic [LW-1:0]        lhs5;
  logic [PW-1:0]        m2_4, c2_4;
  logic signed [PW:0]   up4;
  logic [SB-1:0]        spread4;

  always_comb begin
    m2_4    = PW'(nb4[3]) + PW'(nb4[4]);
    c2_4    = {cen4, 1'b0};
    up4     = $signed({1'b0, c2_4}) - $signed({1'b0, m2_4});
    spread4 = nb4[6] - nb4[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fend5 <= fend4;
      m2_5  <= m2_4;
      c2_5  <= c2_4;
      up5   <= up4;
      gt5   <= (cen4 > nb4[7]);
      lt5   <= (cen4 < nb4[0]);
      lhs5  <= LW'(spread_q8) * LW'(spread4);
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: outlier decision, repair count
  // --------------------------------------------------------------------------
  logic signed [MW-1:0]         up_x, dn_x, thr_x, lhs_x;
  logic                         hot, cold;
  logic [bhpr_pkg::KIND_BITS-1:0] kind5;
  logic [TW-1:0]                rc, rc_next;
  logic [bhpr_pkg::PIX_OUT_BITS-1:0] pix5;
  logic                         new_item;

  always_comb begin
    up_x  = MW'(up5);
    dn_x  = -up_x;
    thr_x = $signed(MW'({min_excess, 1'b0}));
    lhs_x = $signed(MW'(lhs5));
    hot   = (up_x > thr_x) && gt5 && ((up_x <<< 7) > lhs_x);
    cold  = repair_dark && (dn_x > thr_x) && lt5 && ((dn_x <<< 7) > lhs_x);
    if (hot) begin
      kind5 = bhpr_pkg::KIND_HOT;
    end else if (cold) begin
      kind5 = bhpr_pkg::KIND_COLD;
    end else begin
      kind5 = bhpr_pkg::KIND_KEPT;
    end
    pix5     = (kind5 != bhpr_pkg::KIND_KEPT) ? bhpr_pkg::PIX_OUT_BITS'(m2_5)
                                              : bhpr_pkg::PIX_OUT_BITS'(c2_5);
    rc_next  = (kind5 != bhpr_pkg::KIND_KEPT) ? rc + TW'(1) : rc;
    new_item = adv && v5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc <= '0;
    end else if (new_item) begin
      rc <= fend5 ? '0 : rc_next;
    end
  end

  // --------------------------------------------------------------------------
  // output register with a skid slot behind it
  // --------------------------------------------------------------------------
  logic                              ov;
  logic [bhpr_pkg::PIX_OUT_BITS-1:0] skid_pix;
  logic [bhpr_pkg::KIND_BITS-1:0]    skid_kind;
  logic                              skid_fend;
  logic [TW-1:0]                     skid_total;

  assign out_ch.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov         <= 1'b0;
      skid_valid <= 1'b0;
    end else if (ov && out_ch.ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        ov <= new_item;
      end
    end else if (!ov) begin
      ov <= new_item;
    end else if (new_item) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ov && out_ch.ready && skid_valid) begin
      out_ch.pixel_half_levels <= skid_pix;
      out_ch.defect_kind       <= skid_kind;
      out_ch.frame_end         <= skid_fend;
      out_ch.repair_total      <= skid_total;
    end else if ((!ov || out_ch.ready) && new_item) begin
      out_ch.pixel_half_levels <= pix5;
      out_ch.defect_kind       <= kind5;
      out_ch.frame_end         <= fend5;
      out_ch.repair_total      <= rc_next;
    end
    if (ov && !out_ch.ready && new_item) begin
      skid_pix   <= pix5;
      skid_kind  <= kind5;
      skid_fend  <= fend5;
      skid_total <= rc_next;
    end
  end

`ifndef ASSERT_OFF
  // the skid slot only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_ch.valid)
    else $error("skid slot full while output register empty");

  // a repaired sensel is always counted
  a_repair_counted: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.defect_kind != bhpr_pkg::KIND_KEPT))
      |-> (out_ch.repair_total != '0))
    else $error("repair reported with zero total");

  // stored-but-unreleased pixels never exceed the window lag
  a_lag_bound: assert property (@(posedge clk) disable iff (rst)
    (diff <= (DW'({lat_w, 1'b0}) + DW'(2))) || idle)
    else $error("release lag overrun");

  // a stalled output holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.pixel_half_levels) && $stable(out_ch.repair_total)))
    else $error("output changed under stall");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bayer hot pixel repair block: small and large frames with
// random content, spikes and flushes go in, a local median predictor forecasts
// every repaired sensel and the checker compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bhpr_pkg::*;

  localparam logic CMD_DRAIN = 1'b1;
  localparam int   MAXW      = 8192;
  localparam int   LIMIT     = 4000000;
  localparam int   SETTLE    = 24;

  typedef struct packed {
    logic [PIX_OUT_BITS-1:0] pix;
    logic [KIND_BITS-1:0]    kind;
    logic                    fend;
    logic [TOTAL_BITS-1:0]   total;
  } sensel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  bhpr_in_if  in_ch ();
  bhpr_out_if out_ch ();

  bayer_hot_pixel_repair i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  // predictor state: registers, latched frame size, counters, rows in flight
  logic [12:0] min_excess_r;
  logic [12:0] spread_r;
  logic        dark_r;
  logic [13:0] width_r, height_r;
  longint      lat_w, lat_h, col_cnt, row_cnt, out_pos, repairs;
  logic [13:0] rows_mem [0:ROW_SLOTS*MAXW-1];

  sensel_t expected_q[$];
  int      errors     = 0;
  int      pixels_out = 0;
  int      cycles     = 0;
  bit      tx_idle_on = 1'b1;
  bit      rx_idle_on = 1'b1;
  int      hold_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [13:0] neighbour(longint x, longint y);
    if (x < 0) x = 0;
    if (x > lat_w - 1) x = lat_w - 1;
    if (y < 0) y = 0;
    if (y > lat_h - 1) y = lat_h - 1;
    return rows_mem[(y % ROW_SLOTS) * MAXW + (x % MAXW)];
  endfunction

  function automatic bit frame_idle();
    return col_cnt == 0 && row_cnt == 0 && out_pos == 0;
  endfunction

  // advance the median filter by one accepted item, queue what it releases
  task automatic filter_item(input logic cmd, input logic [13:0] s);
    bit      took, emit;
    longint  received, lag, px, py, c, m2, spread, up, down, thr2, gate;
    int      n[8];
    int      k;
    sensel_t r;
    took = 1'b0;
    k    = 0;
    if (cmd == CMD_PIXEL && frame_idle()) begin
      lat_w = (width_r == 0) ? 1 : ((width_r > MAXW) ? MAXW : width_r);
      lat_h = (height_r == 0) ? 1 : height_r;
    end
    if (cmd == CMD_PIXEL && row_cnt < lat_h) begin
      rows_mem[(row_cnt % ROW_SLOTS) * MAXW + (col_cnt % MAXW)] = s;
      took = 1'b1;
      col_cnt++;
      if (col_cnt >= lat_w) begin
        col_cnt = 0;
        row_cnt++;
      end
    end
    received = row_cnt * lat_w + col_cnt;
    lag      = 2 * lat_w + 2;
    emit     = took ? (received > lag + out_pos) : (row_cnt >= lat_h && out_pos < lat_w * lat_h);
    if (!emit) return;
    px = out_pos % lat_w;
    py = out_pos / lat_w;
    c  = neighbour(px, py);
    // same-colour ring two steps out
    for (int dy = -2; dy <= 2; dy += 2) begin
      for (int dx = -2; dx <= 2; dx += 2) begin
        if (dx != 0 || dy != 0) begin
          n[k] = neighbour(px + dx, py + dy);
          k++;
        end
      end
    end
    n.sort();
    m2     = n[3] + n[4];
    spread = n[6] - n[1];
    up     = 2 * c - m2;
    down   = -up;
    thr2   = 2 * longint'(min_excess_r);
    gate   = longint'(spread_r) * spread;
    r.kind = KIND_KEPT;
    if (up > thr2 && c > n[7] && up * 128 > gate) r.kind = KIND_HOT;
    else if (dark_r && down > thr2 && c < n[0] && down * 128 > gate) r.kind = KIND_COLD;
    r.pix = (r.kind != KIND_KEPT) ? PIX_OUT_BITS'(m2) : PIX_OUT_BITS'(2 * c);
    if (r.kind != KIND_KEPT) repairs = (repairs + 1) % (64'd1 << TOTAL_BITS);
    out_pos++;
    r.fend  = (out_pos >= lat_w * lat_h);
    r.total = TOTAL_BITS'(repairs);
    if (r.fend) begin
      out_pos = 0;
      col_cnt = 0;
      row_cnt = 0;
      repairs = 0;
    end
    expected_q.push_back(r);
  endtask

  // ---------------------------------------------------------------- helpers
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // all calls start and end at a falling edge
  task automatic send_item(input logic cmd, input logic [13:0] s);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.sample  <= s;
    do @(posedge clk); while (!in_ch.ready);
    filter_item(cmd, s);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [13:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_EXCESS:   min_excess_r = val[12:0];
      CFG_SPREAD_Q8:    spread_r     = val[12:0];
      CFG_REPAIR_DARK:  dark_r       = val[0];
      CFG_FRAME_WIDTH:  width_r      = val;
      CFG_FRAME_HEIGHT: height_r     = val;
      default: ;
    endcase
  endtask

  // block is idle once every expectation is met and the pipe has drained
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_frame(input logic [13:0] w, input logic [13:0] h);
    wait_quiet();
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
  endtask

  // flat background with noise, hot and cold spikes and the odd wild value
  function automatic logic [13:0] scene_value(int base, int noise);
    int roll, v;
    roll = $urandom_range(99);
    if (roll < 8) v = base + $urandom_range(12000, 600);
    else if (roll < 14) v = base - $urandom_range(12000, 600);
    else if (roll < 20) v = $urandom_range(16383);
    else v = base + $urandom_range(2 * noise) - noise;
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return v[13:0];
  endfunction

  // one frame of pixels, stray drains mid frame, then flush to frame end
  task automatic run_frame(input int stray_pct);
    int base, noise;
    longint count;
    base  = $urandom_range(16383);
    noise = $urandom_range(300);
    count = ((width_r == 0) ? 1 : ((width_r > MAXW) ? MAXW : width_r)) *
            ((height_r == 0) ? 1 : height_r);
    for (longint i = 0; i < count; i++) begin
      if ($urandom_range(99) < stray_pct) send_item(CMD_DRAIN, 14'($urandom));
      send_item(CMD_PIXEL, scene_value(base, noise));
    end
    // a pixel offered while outputs are pending is discarded and acts as a drain
    while (!frame_idle()) begin
      if ($urandom_range(99) < 15) send_item(CMD_PIXEL, 14'($urandom));
      else send_item(CMD_DRAIN, 14'($urandom));
    end
    pixels_out += int'(count);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    logic [13:0] flat[25];
    set_frame(14'd5, 14'd5);
    cfg_write(CFG_MIN_EXCESS, 14'd100);
    cfg_write(CFG_SPREAD_Q8, 14'd0);
    cfg_write(CFG_REPAIR_DARK, 14'd1);
    // drain with nothing pending does nothing
    send_item(CMD_DRAIN, 14'h3FFF);
    for (int i = 0; i < 25; i++) flat[i] = 14'd4000;
    flat[12] = 14'd16383;   // hot center
    flat[6]  = 14'd0;       // cold sensel
    flat[24] = 14'd9000;    // hot at the clamped corner
    flat[0]  = 14'h2AAA;
    flat[1]  = 14'h1555;
    for (int i = 0; i < 25; i++) begin
      if (i == 10) send_item(CMD_DRAIN, 14'd0);   // drain in mid frame
      send_item(CMD_PIXEL, flat[i]);
    end
    send_item(CMD_PIXEL, 14'd123);                 // pixel after last, acts as drain
    while (!frame_idle()) send_item(CMD_DRAIN, 14'd0);
  endtask

  task automatic test_size_extremes();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_frame(14'd0, 14'd0);              // both count as one
    run_frame(0);
    set_frame(14'h3FFF, 14'd1);           // saturates to the widest line
    run_frame(0);
    set_frame(14'd1, 14'd8192);           // single column, 8192 rows
    run_frame(0);
    set_frame(14'd8192, 14'd2);
    run_frame(0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_thresholds();
    logic [13:0] ex[2];
    logic [13:0] sp[2];
    ex[0] = 14'd100;  ex[1] = 14'd8000;
    sp[0] = 14'd0;    sp[1] = 14'd5120;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        set_frame(14'd7, 14'd5);
        cfg_write(CFG_MIN_EXCESS, ex[a]);
        cfg_write(CFG_SPREAD_Q8, sp[b]);
        cfg_write(CFG_REPAIR_DARK, 14'(b));
        run_frame(3);
      end
    end
  endtask

  task automatic test_random();
    while (pixels_out < 1100) begin
      set_frame(14'($urandom_range(12, 1)), 14'($urandom_range(8, 1)));
      cfg_write(CFG_MIN_EXCESS, 14'($urandom_range(8000, 100)));
      cfg_write(CFG_SPREAD_Q8, 14'($urandom_range(99) < 20 ? 0 : $urandom_range(5120)));
      cfg_write(CFG_REPAIR_DARK, 14'($urandom_range(1)));
      tx_idle_on = ($urandom_range(3) != 0);
      rx_idle_on = ($urandom_range(3) != 0);
      run_frame(4);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    set_frame(14'd40, 14'd4);
    tx_idle_on  = 1'b0;
    hold_cycles = 400;
    run_frame(0);
    tx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else if (rx_idle_on) begin
      out_ch.ready <= ($urandom_range(99) >= 25) || ($urandom_range(99) < 2 ? 1'b0 : 1'b0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    sensel_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: pix %0d", out_ch.pixel_half_levels);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.pixel_half_levels !== e.pix) begin
          $error("pixel_half_levels expected %0d got %0d", e.pix, out_ch.pixel_half_levels);
          errors++;
        end
        if (out_ch.defect_kind !== e.kind) begin
          $error("defect_kind expected %0d got %0d", e.kind, out_ch.defect_kind);
          errors++;
        end
        if (out_ch.frame_end !== e.fend) begin
          $error("frame_end expected %0d got %0d", e.fend, out_ch.frame_end);
          errors++;
        end
        if (out_ch.repair_total !== e.total) begin
          $error("repair_total expected %0d got %0d", e.total, out_ch.repair_total);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_PIXEL;
    in_ch.sample  = '0;
    out_ch.ready  = 1'b0;
    min_excess_r = MIN_EXCESS_RESET;
    spread_r     = SPREAD_Q8_RESET;
    dark_r       = 1'b0;
    width_r      = FRAME_WIDTH_RESET;
    height_r     = FRAME_HEIGHT_RESET;
    lat_w = FRAME_WIDTH_RESET;
    lat_h = FRAME_HEIGHT_RESET;
    col_cnt = 0;
    row_cnt = 0;
    out_pos = 0;
    repairs = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_thresholds();
    test_backpressure();
    test_size_extremes();
    test_random();

    wait_quiet();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
